// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands used by the port checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// property checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

// ----- hdl/ifmt_pkg.sv -----
// ----------------------------------------------------------------------------
// ifmt_pkg
// types and constants of the integer field formatter
// ----------------------------------------------------------------------------
package ifmt_pkg;

    localparam int VAL_W      = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIG_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 7;

    // a field never exceeds this many characters
    localparam logic [CNT_W-1:0] OUT_LIMIT = 7'd64;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    // 'a' minus ten, so nibble 10 maps to 'a'
    localparam logic [7:0] CH_HEX_OFS = 8'h57;

    localparam logic CMD_DEC = 1'b0;
    localparam logic CMD_HEX = 1'b1;

    typedef enum logic [1:0] {
        CT_IDLE,
        CT_START,
        CT_CONV,
        CT_BUSY
    } ctl_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_NORM,
        EM_EMIT
    } emit_state_t;

    typedef struct packed {
        logic [DIG_W-1:0] digits;
        logic             neg;
        logic             has_prec;
        logic [CNT_W-1:0] prec;
        logic [CNT_W-1:0] width;
        logic             zero_val;
    } ifmt_load_t;

endpackage

// ----- hdl/ifmt_bin2bcd.sv -----
// ----------------------------------------------------------------------------
// ifmt_bin2bcd
// bit-serial binary to bcd converter, one input bit per cycle (shift-add-3)
// ----------------------------------------------------------------------------
module ifmt_bin2bcd import ifmt_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [VAL_W-1:0] bin_in,
    output logic             done,
    output logic [DIG_W-1:0] bcd_out
);

    localparam int BIT_CNT_W = $clog2(VAL_W);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(VAL_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0]     bin_reg, bin_next;
    logic [DIG_W-1:0]     bcd_reg, bcd_next;
    logic [DIG_W-1:0]     adj;

    // digits of five or more get three added before the shift
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                        : bcd_reg[i*4 +: 4];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = bin_in;
            bcd_next  = '0;
        end else if (busy_reg) begin
            bcd_next = {adj[DIG_W-2:0], bin_reg[VAL_W-1]};
            bin_next = {bin_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done    = done_reg;
    assign bcd_out = bcd_reg;

endmodule

// ----- hdl/ifmt_emitter.sv -----
// ----------------------------------------------------------------------------
// ifmt_emitter
// digit shift register, leading-zero strip and character sequencer
// ----------------------------------------------------------------------------
module ifmt_emitter import ifmt_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       load,
    input  ifmt_load_t load_data,
    output logic       idle,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last
);

    emit_state_t      state_reg, state_next;
    logic [DIG_W-1:0] dig_reg;
    logic [3:0]       ndig_reg;
    logic             neg_reg, has_prec_reg, zero_val_reg;
    logic [CNT_W-1:0] prec_reg, width_reg;
    logic [CNT_W-1:0] npad_reg, sign_end_reg, zero_end_reg, len_reg, pos_reg;
    logic             valid_reg;
    logic [7:0]       char_reg;
    logic             last_reg;

    logic [3:0]       top_nib;
    logic             norm_shift, fin, emit_fire, emit_last, in_digits;
    logic [CNT_W-1:0] ndig_eff, plen, body, total, len_fin;
    logic [7:0]       char_next;

    assign top_nib = dig_reg[DIG_W-1 -: 4];

    // field layout once the digit count is settled
    always_comb begin
        ndig_eff = (has_prec_reg && prec_reg == '0 && zero_val_reg) ? '0
                                                                    : CNT_W'(ndig_reg);
        plen     = (has_prec_reg && prec_reg > ndig_eff) ? prec_reg : ndig_eff;
        body     = plen + CNT_W'(neg_reg);
        total    = (width_reg > body) ? width_reg : body;
        len_fin  = (total > OUT_LIMIT) ? OUT_LIMIT : total;
    end

    always_comb begin
        in_digits = (pos_reg >= zero_end_reg);
        if (pos_reg < npad_reg) begin
            char_next = CH_SPACE;
        end else if (pos_reg < sign_end_reg) begin
            char_next = CH_MINUS;
        end else if (!in_digits) begin
            char_next = CH_ZERO;
        end else if (top_nib < 4'd10) begin
            char_next = {4'h0, top_nib} + CH_ZERO;
        end else begin
            char_next = {4'h0, top_nib} + CH_HEX_OFS;
        end
    end

    // outputs of the sequencer
    always_comb begin
        idle       = (state_reg == EM_IDLE);
        norm_shift = (state_reg == EM_NORM) && (top_nib == 4'h0) && (ndig_reg > 4'd1);
        fin        = (state_reg == EM_NORM) && !norm_shift;
        emit_fire  = (state_reg == EM_EMIT) && (!valid_reg || m_ready);
        emit_last  = (pos_reg == len_reg - 1'b1);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            EM_IDLE: begin
                if (load) state_next = EM_NORM;
            end
            EM_NORM: begin
                if (fin) state_next = (len_fin == '0) ? EM_IDLE : EM_EMIT;
            end
            EM_EMIT: begin
                if (emit_fire && emit_last) state_next = EM_IDLE;
            end
            default: state_next = EM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= EM_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit_fire) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && state_reg == EM_IDLE) begin
            dig_reg      <= load_data.digits;
            ndig_reg     <= 4'(NUM_DIGITS);
            neg_reg      <= load_data.neg;
            has_prec_reg <= load_data.has_prec;
            prec_reg     <= load_data.prec;
            width_reg    <= load_data.width;
            zero_val_reg <= load_data.zero_val;
        end else if (norm_shift) begin
            dig_reg  <= {dig_reg[DIG_W-5:0], 4'h0};
            ndig_reg <= ndig_reg - 1'b1;
        end else if (emit_fire && in_digits) begin
            dig_reg <= {dig_reg[DIG_W-5:0], 4'h0};
        end
        if (fin) begin
            npad_reg     <= total - body;
            sign_end_reg <= total - plen;
            zero_end_reg <= total - ndig_eff;
            len_reg      <= len_fin;
            pos_reg      <= '0;
        end else if (emit_fire) begin
            pos_reg <= pos_reg + 1'b1;
        end
        if (emit_fire) begin
            char_reg <= char_next;
            last_reg <= emit_last;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_char = char_reg;
    assign m_last     = last_reg;

endmodule

// ----- hdl/integer_field_formatter_unit.sv -----
// ----------------------------------------------------------------------------
// integer_field_formatter_unit
// printf-style integer field formatter, one ascii character per transfer
// ----------------------------------------------------------------------------
// input channel s_*: command (0 signed decimal, 1 lowercase hex), value,
// min_width and a signed precision (negative means none). result channel m_*:
// one character per transfer, m_last on the final character of the field.
// a field with no characters (zero, precision 0, width 0) gives no transfer.
// one field is worked on at a time; s_ready is high only while idle.
// an input transfer is registered, then a start state hands the value on: hex
// goes straight to the emitter, while decimal first passes the bit-serial bcd
// conversion, one value bit per cycle. the emitter then strips leading zeros,
// one digit per cycle, and settles the field layout. characters then leave at
// one per cycle while the receiver takes them; a new field is accepted only
// once the emitter has issued the last character of the current one.
// the last character sits in the output register while the next field is
// accepted and converted. a stalled receiver holds the current character and
// pauses the sequencer. synchronous reset clears all control state and drops
// m_valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
module integer_field_formatter_unit import ifmt_pkg::*; #(
    parameter int MAX_WIDTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [31:0]       s_value,
    input  logic [6:0]        s_min_width,
    input  logic signed [6:0] s_precision,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_char,
    output logic              m_last
);

    localparam logic [CNT_W-1:0] MAX_W = CNT_W'(MAX_WIDTH);

    ctl_state_t       state_reg, state_next;
    logic             cmd_reg, neg_reg, has_prec_reg, zero_reg;
    logic [VAL_W-1:0] mag_reg;
    logic [CNT_W-1:0] width_reg, prec_reg;

    logic             accept;
    logic             bcd_start, bcd_done;
    logic [DIG_W-1:0] bcd;
    logic             em_load, em_idle;
    ifmt_load_t       load_data;

    assign accept = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CT_IDLE: begin
                if (accept) state_next = CT_START;
            end
            CT_START: begin
                state_next = (cmd_reg == CMD_HEX) ? CT_BUSY : CT_CONV;
            end
            CT_CONV: begin
                if (bcd_done) state_next = CT_BUSY;
            end
            CT_BUSY: begin
                if (em_idle) state_next = CT_IDLE;
            end
            default: state_next = CT_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == CT_IDLE);
        bcd_start = (state_reg == CT_START) && (cmd_reg == CMD_DEC);
        em_load   = ((state_reg == CT_START) && (cmd_reg == CMD_HEX)) ||
                    ((state_reg == CT_CONV) && bcd_done);
        load_data.digits   = (cmd_reg == CMD_HEX) ? {{(DIG_W-VAL_W){1'b0}}, mag_reg} : bcd;
        load_data.neg      = neg_reg;
        load_data.has_prec = has_prec_reg;
        load_data.prec     = prec_reg;
        load_data.width    = width_reg;
        load_data.zero_val = zero_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // capture the item, take the magnitude and clamp width and precision
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_command;
            neg_reg      <= (s_command == CMD_DEC) && s_value[VAL_W-1];
            mag_reg      <= ((s_command == CMD_DEC) && s_value[VAL_W-1]) ? ~s_value + 1'b1
                                                                         : s_value;
            zero_reg     <= (s_value == '0);
            width_reg    <= (s_min_width > MAX_W) ? MAX_W : s_min_width;
            has_prec_reg <= !s_precision[6];
            if (s_precision[6]) begin
                prec_reg <= '0;
            end else begin
                prec_reg <= ($unsigned(s_precision) > MAX_W) ? MAX_W : $unsigned(s_precision);
            end
        end
    end

    ifmt_bin2bcd u_bin2bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .bin_in  (mag_reg),
        .done    (bcd_done),
        .bcd_out (bcd)
    );

    ifmt_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (em_load),
        .load_data  (load_data),
        .idle       (em_idle),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

endmodule

// ----- hdl/ifmt_checker.sv -----
// ----------------------------------------------------------------------------
// ifmt_checker
// port-level checks of the integer field formatter, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifmt_checker import ifmt_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic [7:0]        m_out_char,
    input logic              m_last
);

    logic [8:0] out_beat;
    logic       char_ok;

    assign out_beat = {m_out_char, m_last};

    // only pad, sign and digit characters appear
    assign char_ok = (m_out_char == CH_SPACE) || (m_out_char == CH_MINUS) ||
                     (m_out_char >= 8'h30 && m_out_char <= 8'h39) ||
                     (m_out_char >= 8'h61 && m_out_char <= 8'h66);

    // a stalled character holds
    `ASSERT_CLK(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(out_beat))

    // reset empties the output register
    `ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

    // one field at a time: no second transfer right after one
    `ASSERT_CLK(a_one_field, aclk, aresetn, s_valid && s_ready |=> !s_ready)

    // while idle only the final character of a field can still wait
    `ASSERT_CLK(a_idle_last, aclk, aresetn, s_ready && m_valid |-> m_last)

    `ASSERT_CLK(a_char_set, aclk, aresetn, m_valid |-> char_ok)

endmodule

bind integer_field_formatter_unit ifmt_checker u_ifmt_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_char  (m_out_char),
    .m_last      (m_last)
);

// ----- sim/integer_field_formatter_unit_test.sv -----
// ----------------------------------------------------------------------------
// integer_field_formatter_unit_test
// self-checking bench for the printf-style integer field formatter
// ----------------------------------------------------------------------------
// fields are sent on the s_ channel with random gaps, and the m_ characters
// are taken with random stalls. each accepted field is formatted by a local
// predictor into a queue of characters that every m_ transfer is checked
// against. directed fields first, then random phases, then a long receiver
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module integer_field_formatter_unit_test;
    import ifmt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_MAX   = 64;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int DRAIN_WAIT  = 100;

    // 7-bit precision encodings
    localparam logic signed [6:0] PREC_NONE = -7'sd1;
    localparam logic signed [6:0] PREC_MOST_NEG = -7'sd64;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_command;
    logic [31:0]       s_value;
    logic [6:0]        s_min_width;
    logic signed [6:0] s_precision;
    logic              m_valid;
    logic              m_ready;
    logic [7:0]        m_out_char;
    logic              m_last;

    char_beat_t pending_chars[$];
    int         mismatches   = 0;
    int         cycle_count  = 0;
    int         hold_cycles  = 0;
    bit         send_gaps    = 1'b1;
    bit         recv_stalls  = 1'b1;

    integer_field_formatter_unit #(
        .MAX_WIDTH(FIELD_MAX)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_value    (s_value),
        .s_min_width(s_min_width),
        .s_precision(s_precision),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_last     (m_last)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // builds the characters of one field: spaces, sign, zeros, digits
    function automatic void format_field(input logic cmd, input logic [31:0] val,
                                         input logic [6:0] wid,
                                         input logic signed [6:0] prec);
        int          fw;
        int          pr;
        int          base;
        int          ndig;
        int          plen;
        int          total;
        int          sign_len;
        int          n;
        int          k;
        int          d;
        bit          has_prec;
        bit          neg;
        logic [31:0] mag;
        logic [7:0]  digs[16];
        logic [7:0]  text[$];
        char_beat_t  beat;

        fw       = (int'(wid) > FIELD_MAX) ? FIELD_MAX : int'(wid);
        pr       = int'(prec);
        has_prec = (pr >= 0);
        if (pr > FIELD_MAX)
            pr = FIELD_MAX;
        neg  = 1'b0;
        mag  = val;
        base = 10;
        if (cmd == CMD_HEX) begin
            base = 16;
        end else if (val[31]) begin
            neg = 1'b1;
            mag = ~val + 32'd1;
        end

        ndig = 0;
        do begin
            d = int'(mag % base);
            digs[ndig] = (d < 10) ? 8'("0" + d) : 8'("a" + d - 10);
            ndig++;
            mag = mag / base;
        end while (mag != 0);

        // zero with precision 0 prints no digits at all
        if (has_prec && pr == 0 && val == 32'd0)
            ndig = 0;
        plen = ndig;
        if (has_prec && pr > plen)
            plen = pr;
        sign_len = neg ? 1 : 0;
        total = plen + sign_len;
        if (fw > total)
            total = fw;

        repeat (total - plen - sign_len) text.push_back(" ");
        if (neg)
            text.push_back("-");
        repeat (plen - ndig) text.push_back("0");
        for (k = ndig - 1; k >= 0; k--)
            text.push_back(digs[k]);

        n = (text.size() > FIELD_MAX) ? FIELD_MAX : text.size();
        for (k = 0; k < n; k++) begin
            beat.ch   = text[k];
            beat.last = (k == n - 1);
            pending_chars.push_back(beat);
        end
    endfunction

    // one field on the s_ channel; expectations are queued at the transfer
    task automatic send_field(input logic cmd, input logic [31:0] val,
                              input logic [6:0] wid, input logic signed [6:0] prec);
        int gap;

        gap = send_gaps ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_command   = cmd;
        s_value     = val;
        s_min_width = wid;
        s_precision = prec;
        s_valid     = 1'b1;
        do @(posedge aclk); while (!s_ready);
        format_field(cmd, val, wid, prec);
        @(negedge aclk);
    endtask

    task automatic send_random_field();
        logic [31:0]       val;
        logic [6:0]        wid;
        logic signed [6:0] prec;

        case ($urandom_range(0, 6))
            0: val = $urandom_range(0, 9);
            1: val = $urandom_range(0, 4095);
            2: val = $urandom;
            3: val = -$urandom_range(1, 100000);
            4: val = $urandom >> $urandom_range(0, 31);
            5: val = 32'h8000_0000 + $urandom_range(0, 1);
            default: val = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF};
        endcase
        wid = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, 14));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: prec = PREC_NONE;
            4, 5, 6: prec = 7'($urandom_range(0, 12));
            7: begin
                prec = 7'sd0;
                if ($urandom_range(0, 1))
                    val = 32'd0;
            end
            default: prec = 7'($urandom_range(0, 127));
        endcase
        send_field(1'($urandom_range(0, 1)), val, wid, prec);
    endtask

    // receiver: random stall before each character, or a long hold when asked
    initial begin
        int gap;

        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            if (hold_cycles > 0) begin
                m_ready = 1'b0;
                while (hold_cycles > 0) begin
                    @(negedge aclk);
                    hold_cycles--;
                end
            end
            gap = recv_stalls ? $urandom_range(0, 17) : 0;
            if (gap > 0) begin
                m_ready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        char_beat_t want;

        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: char %h last %b", m_out_char, m_last);
            end else begin
                want = pending_chars.pop_front();
                if (m_out_char !== want.ch || m_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected char %h last %b, got char %h last %b",
                                 want.ch, want.last, m_out_char, m_last);
                end
            end
        end
    end

    task automatic test_directed();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        send_field(CMD_DEC, 32'd0,          7'd0,   PREC_NONE);
        // empty fields give no transfer at all
        send_field(CMD_DEC, 32'd0,          7'd0,   7'sd0);
        send_field(CMD_HEX, 32'd0,          7'd0,   7'sd0);
        send_field(CMD_DEC, 32'd0,          7'd5,   7'sd0);
        send_field(CMD_HEX, 32'd0,          7'd1,   PREC_NONE);
        send_field(CMD_DEC, 32'h7FFF_FFFF,  7'd0,   PREC_NONE);
        send_field(CMD_DEC, 32'h8000_0000,  7'd0,   PREC_NONE);
        send_field(CMD_DEC, 32'hFFFF_FFFF,  7'd0,   PREC_NONE);
        send_field(CMD_HEX, 32'hFFFF_FFFF,  7'd0,   PREC_NONE);
        send_field(CMD_HEX, 32'h8000_0000,  7'd0,   PREC_NONE);
        send_field(CMD_HEX, 32'h0123_ABCD,  7'd12,  7'sd10);
        // sign plus 63 digits fills the whole field limit
        send_field(CMD_DEC, 32'h8000_0000,  7'd0,   7'sd63);
        send_field(CMD_DEC, -32'sd5,        7'd64,  PREC_NONE);
        // widths beyond the limit are clamped
        send_field(CMD_DEC, 32'd42,         7'd127, PREC_NONE);
        send_field(CMD_HEX, 32'hDEAD_BEEF,  7'd65,  7'sd0);
        send_field(CMD_DEC, 32'd42,         7'd100, 7'sd63);
        send_field(CMD_HEX, 32'h0000_0ABC,  7'd3,   7'sd63);
        // any negative precision means none
        send_field(CMD_DEC, 32'd7,          7'd10,  PREC_MOST_NEG);
        send_field(CMD_DEC, 32'd7,          7'd10,  -7'sd2);
        send_field(CMD_HEX, 32'd7,          7'd0,   7'sd1);
        send_field(CMD_DEC, 32'd12345,      7'd3,   7'sd2);
        send_field(CMD_DEC, -32'sd123,      7'd8,   7'sd6);
        send_field(CMD_DEC, 32'd1000000000, 7'd11,  PREC_NONE);
        send_field(CMD_HEX, 32'h5555_AAAA,  7'h2A,  7'sh55);
    endtask

    task automatic test_random();
        int phase;

        for (phase = 0; phase < 5; phase++) begin
            // phase 1 runs with no gaps on either side
            send_gaps   = (phase != 1) && (phase != 3);
            recv_stalls = (phase != 1) && (phase != 2);
            repeat (100) send_random_field();
        end
    endtask

    task automatic test_backpressure();
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        hold_cycles = 600;
        repeat (12) send_random_field();
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        hold_cycles = 300;
        repeat (12) send_random_field();
    endtask

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_command   = CMD_DEC;
        s_value     = '0;
        s_min_width = '0;
        s_precision = PREC_NONE;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_directed();
        test_random();
        test_backpressure();
        s_valid = 1'b0;

        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0 && pending_chars.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ifmt_pkg.sv
hdl/ifmt_bin2bcd.sv
hdl/ifmt_emitter.sv
hdl/integer_field_formatter_unit.sv
hdl/ifmt_checker.sv
sim/integer_field_formatter_unit_test.sv
